### rtl/core/alab_pkg.sv
// Package: constants, control word types, microcode ROM and log table.
`timescale 1ns / 1ps
`default_nettype none
package alab_pkg;

  localparam int LUX_FRACTION_BITS = 8;
  localparam int LOG_TABLE_BITS    = 6;
  localparam int LOG_TABLE_SIZE    = 1 << LOG_TABLE_BITS;
  localparam int LUX_W             = 16 + LUX_FRACTION_BITS;
  localparam int LEAD_W            = $clog2(LUX_W);
  localparam int LG_W              = LEAD_W + 16;
  localparam int MUL_W             = 32;
  localparam int PROD_W            = 2 * MUL_W;
  localparam int LIN_SHIFT         = LUX_FRACTION_BITS + 2;
  localparam int LIN_W             = 11;
  localparam int RES_W             = 7;
  localparam int CFG_W             = 16;
  localparam int CFG_IDX_W         = 2;
  localparam int STEP_W            = 4;

  localparam logic [LUX_W-1:0] LUX_HUNDRED   = LUX_W'(100 << LUX_FRACTION_BITS);
  localparam logic [MUL_W-1:0] LIN_SLOPE     = MUL_W'(49);
  localparam logic [MUL_W-1:0] LOG_SLOPE     = MUL_W'(99);
  localparam logic [MUL_W-1:0] LOG10_2_Q32   = MUL_W'(1292913986);
  localparam logic [MUL_W-1:0] RECIP_25_Q16  = MUL_W'(2622);
  localparam int               LOG_OUT_SHIFT = 50;
  localparam int               LIN_OUT_SHIFT = 16;

  localparam logic [CFG_W-1:0] SCALE_RESET   = CFG_W'(3775);
  localparam logic [CFG_W-1:0] FALL_RESET    = CFG_W'(32768);
  localparam logic [CFG_W-1:0] RISE_RESET    = CFG_W'(3277);

  localparam logic [RES_W-1:0] BRIGHT_MIN    = RES_W'(1);
  localparam logic [RES_W-1:0] BRIGHT_MAX    = RES_W'(100);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCALE = 2'd0,
    REG_FALL  = 2'd1,
    REG_RISE  = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    MS_NONE,
    MS_LUX,
    MS_FILT,
    MS_S49,
    MS_LG99,
    MS_LOG10,
    MS_RECIP
  } mul_sel_t;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_LUX,
    ACT_UPDATE,
    ACT_LOG,
    ACT_EMIT_LOG,
    ACT_EMIT_LIN
  } act_t;

  typedef enum logic [1:0] {
    JC_NONE,
    JC_UNPRIMED,
    JC_LINEAR
  } jump_cond_t;

  typedef struct packed {
    mul_sel_t            mul_sel;
    act_t                act;
    jump_cond_t          cond;
    logic [STEP_W-1:0]   target;
    logic                last;
  } ctrl_word_t;

  typedef struct packed {
    logic unprimed;
    logic linear;
  } seq_cond_t;

  localparam logic [STEP_W-1:0] ST_MUL_LUX  = 4'd0;
  localparam logic [STEP_W-1:0] ST_LUX      = 4'd1;
  localparam logic [STEP_W-1:0] ST_MUL_FILT = 4'd2;
  localparam logic [STEP_W-1:0] ST_UPDATE   = 4'd3;
  localparam logic [STEP_W-1:0] ST_LOG      = 4'd4;
  localparam logic [STEP_W-1:0] ST_MUL99    = 4'd5;
  localparam logic [STEP_W-1:0] ST_MULC     = 4'd6;
  localparam logic [STEP_W-1:0] ST_EMIT_LOG = 4'd7;
  localparam logic [STEP_W-1:0] ST_LIN      = 4'd8;
  localparam logic [STEP_W-1:0] ST_EMIT_LIN = 4'd9;

  localparam ctrl_word_t IDLE_WORD = '{MS_NONE, ACT_NONE, JC_NONE, ST_MUL_LUX, 1'b0};

  function automatic ctrl_word_t rom_word(input logic [STEP_W-1:0] step);
    ctrl_word_t w;
    w = IDLE_WORD;
    unique case (step)
      ST_MUL_LUX:  w = '{MS_LUX,   ACT_NONE,     JC_NONE,     ST_MUL_LUX, 1'b0};
      ST_LUX:      w = '{MS_NONE,  ACT_LUX,      JC_UNPRIMED, ST_LOG,     1'b0};
      ST_MUL_FILT: w = '{MS_FILT,  ACT_NONE,     JC_NONE,     ST_MUL_LUX, 1'b0};
      ST_UPDATE:   w = '{MS_NONE,  ACT_UPDATE,   JC_NONE,     ST_MUL_LUX, 1'b0};
      ST_LOG:      w = '{MS_S49,   ACT_LOG,      JC_LINEAR,   ST_LIN,     1'b0};
      ST_MUL99:    w = '{MS_LG99,  ACT_NONE,     JC_NONE,     ST_MUL_LUX, 1'b0};
      ST_MULC:     w = '{MS_LOG10, ACT_NONE,     JC_NONE,     ST_MUL_LUX, 1'b0};
      ST_EMIT_LOG: w = '{MS_NONE,  ACT_EMIT_LOG, JC_NONE,     ST_MUL_LUX, 1'b1};
      ST_LIN:      w = '{MS_RECIP, ACT_NONE,     JC_NONE,     ST_MUL_LUX, 1'b0};
      ST_EMIT_LIN: w = '{MS_NONE,  ACT_EMIT_LIN, JC_NONE,     ST_MUL_LUX, 1'b1};
      default:     w = '{MS_NONE,  ACT_NONE,     JC_NONE,     ST_MUL_LUX, 1'b1};
    endcase
    return w;
  endfunction

  typedef logic [15:0] log_table_t [LOG_TABLE_SIZE];

  // log2(1 + i/size) in Q0.16 by repeated squaring of a Q1.30 mantissa
  function automatic log_table_t build_log_table();
    log_table_t tbl;
    logic [63:0] m;
    logic [15:0] r;
    for (int i = 0; i < LOG_TABLE_SIZE; i++) begin
      m = 64'(LOG_TABLE_SIZE + i) << (30 - LOG_TABLE_BITS);
      r = '0;
      for (int k = 0; k < 16; k++) begin
        m = (m * m) >> 30;
        r = {r[14:0], 1'b0};
        if (m >= (64'd1 << 31)) begin
          m = m >> 1;
          r[0] = 1'b1;
        end
      end
      tbl[i] = r;
    end
    return tbl;
  endfunction

  localparam log_table_t LOG_TABLE = build_log_table();

endpackage
`default_nettype wire

### rtl/core/alab_if.sv
// Interfaces: sample and result channels.
`timescale 1ns / 1ps
`default_nettype none
interface alab_sample_if;
  logic        valid;
  logic        ready;
  logic [15:0] raw_count;
  logic        fresh_sample;

  modport source (output valid, output raw_count, output fresh_sample, input ready);
  modport sink   (input valid, input raw_count, input fresh_sample, output ready);
endinterface

interface alab_result_if;
  logic       valid;
  logic       ready;
  logic [6:0] brightness_percent;

  modport source (output valid, output brightness_percent, input ready);
  modport sink   (input valid, input brightness_percent, output ready);
endinterface
`default_nettype wire

### rtl/core/alab_seq.sv
// Microcode sequencer: step counter, control ROM and conditional jumps.
`timescale 1ns / 1ps
`default_nettype none
module alab_seq (
  input  wire                       clk,
  input  wire                       rst,
  input  wire                       start,
  input  wire                       fresh,
  input  wire                       stall,
  input  wire alab_pkg::seq_cond_t  cond,
  output alab_pkg::ctrl_word_t      ctrl,
  output logic                      busy
);
  import alab_pkg::*;

  logic              running;
  logic              running_next;
  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;
  ctrl_word_t        word;
  logic              take_jump;

  assign word = rom_word(step);
  assign ctrl = running ? word : IDLE_WORD;
  assign busy = running;

  always_comb begin
    take_jump = 1'b0;
    unique case (word.cond)
      JC_UNPRIMED: take_jump = cond.unprimed;
      JC_LINEAR:   take_jump = cond.linear;
      default:     take_jump = 1'b0;
    endcase
  end

  always_comb begin
    running_next = running;
    step_next    = step;
    if (!running) begin
      if (start) begin
        running_next = 1'b1;
        step_next    = fresh ? ST_MUL_LUX : ST_LOG;
      end
    end else if (!stall) begin
      if (word.last) begin
        running_next = 1'b0;
      end else if (take_jump) begin
        step_next = word.target;
      end else begin
        step_next = step + STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      step    <= ST_MUL_LUX;
    end else begin
      running <= running_next;
      step    <= step_next;
    end
  end

endmodule
`default_nettype wire

### rtl/core/ambient_light_auto_brightness.sv
// Top level: auto-brightness datapath around a shared multiplier.
`timescale 1ns / 1ps
`default_nettype none
// Converts a raw light-sensor count to lux, smooths it with an asymmetric
// exponential filter (fast fall, slow rise, gains in registers 1 and 2) and
// returns a brightness of 1..100 percent per item: linear below 100 lux,
// logarithmic from 100 lux up. One item is in flight at a time; a fresh
// reading is scaled to lux and filtered first (the very first reading loads
// the filter directly), a recompute-only item starts at the log/linear step.
// All multiplying microcode steps share one registered 32x32 multiplier. The next
// item is taken while a finished result still waits in the output register.
module ambient_light_auto_brightness (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                cfg_we,
  input  wire [alab_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire [alab_pkg::CFG_W-1:0]          cfg_data,
  alab_sample_if.sink                        sample_ch,
  alab_result_if.source                      result_ch
);
  import alab_pkg::*;

  logic [CFG_W-1:0]  scale;
  logic [CFG_W-1:0]  fall_gain;
  logic [CFG_W-1:0]  rise_gain;

  logic [15:0]       count;
  logic [LUX_W-1:0]  smoothed;
  logic              primed;
  logic [LUX_W-1:0]  diff;
  logic              falling;
  logic [LG_W-1:0]   lg;
  logic [PROD_W-1:0] prod;
  logic              out_valid;
  logic [RES_W-1:0]  out_data;

  ctrl_word_t        ctrl;
  seq_cond_t         cond;
  logic              busy;
  logic              start;
  logic              emit;
  logic              stall;

  logic [MUL_W-1:0]  mul_a;
  logic [MUL_W-1:0]  mul_b;
  logic [LUX_W-1:0]  lux;
  logic [LUX_W-1:0]  delta;
  logic [LEAD_W-1:0] lead;
  logic [LEAD_W-1:0] norm_shift;
  logic [LUX_W-1:0]  norm;
  logic [LOG_TABLE_BITS-1:0] idx;
  logic [9:0]        bright_log;
  logic [RES_W-1:0]  bright_lin;
  logic [RES_W-1:0]  bright;

  assign start           = sample_ch.valid && sample_ch.ready;
  assign sample_ch.ready = !busy;
  assign emit            = (ctrl.act == ACT_EMIT_LOG) || (ctrl.act == ACT_EMIT_LIN);
  assign stall           = emit && out_valid && !result_ch.ready;
  assign cond.unprimed   = !primed;
  assign cond.linear     = smoothed < LUX_HUNDRED;

  alab_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .fresh (sample_ch.fresh_sample),
    .stall (stall),
    .cond  (cond),
    .ctrl  (ctrl),
    .busy  (busy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      scale     <= SCALE_RESET;
      fall_gain <= FALL_RESET;
      rise_gain <= RISE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SCALE: scale     <= cfg_data;
        REG_FALL:  fall_gain <= cfg_data;
        REG_RISE:  rise_gain <= cfg_data;
        default:   ;
      endcase
    end
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (ctrl.mul_sel)
      MS_LUX: begin
        mul_a = MUL_W'(count);
        mul_b = MUL_W'(scale);
      end
      MS_FILT: begin
        mul_a = MUL_W'(diff);
        mul_b = MUL_W'(falling ? fall_gain : rise_gain);
      end
      MS_S49: begin
        mul_a = MUL_W'(smoothed);
        mul_b = LIN_SLOPE;
      end
      MS_LG99: begin
        mul_a = MUL_W'(lg);
        mul_b = LOG_SLOPE;
      end
      MS_LOG10: begin
        mul_a = prod[MUL_W-1:0];
        mul_b = LOG10_2_Q32;
      end
      MS_RECIP: begin
        mul_a = MUL_W'(prod[LIN_SHIFT +: LIN_W]);
        mul_b = RECIP_25_Q16;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctrl.mul_sel != MS_NONE) begin
      prod <= mul_a * mul_b;
    end
  end

  assign lux   = prod[(16 - LUX_FRACTION_BITS) +: LUX_W];
  assign delta = prod[16 +: LUX_W];

  always_comb begin
    lead = '0;
    for (int i = 0; i < LUX_W; i++) begin
      if (smoothed[i]) begin
        lead = LEAD_W'(i);
      end
    end
  end

  assign norm_shift = LEAD_W'(LUX_W - 1) - lead;
  assign norm       = smoothed << norm_shift;
  assign idx        = norm[LUX_W-2 -: LOG_TABLE_BITS];

  always_ff @(posedge clk) begin
    if (start) begin
      count <= sample_ch.raw_count;
    end
    unique case (ctrl.act)
      ACT_LUX: begin
        falling <= lux < smoothed;
        diff    <= (lux < smoothed) ? smoothed - lux : lux - smoothed;
      end
      ACT_LOG: begin
        lg <= {lead - LEAD_W'(LUX_FRACTION_BITS), LOG_TABLE[idx]};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      smoothed <= '0;
      primed   <= 1'b0;
    end else begin
      unique case (ctrl.act)
        ACT_LUX: begin
          if (!primed) begin
            smoothed <= lux;
            primed   <= 1'b1;
          end
        end
        ACT_UPDATE: begin
          smoothed <= falling ? smoothed - delta : smoothed + delta;
        end
        default: ;
      endcase
    end
  end

  assign bright_log = 10'(prod[LOG_OUT_SHIFT +: 9]) + 10'd1;
  assign bright_lin = RES_W'(prod[LIN_OUT_SHIFT +: 6]) + BRIGHT_MIN;

  always_comb begin
    if (ctrl.act == ACT_EMIT_LIN) begin
      bright = bright_lin;
    end else if (bright_log > 10'(BRIGHT_MAX)) begin
      bright = BRIGHT_MAX;
    end else begin
      bright = bright_log[RES_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit && !stall) begin
      out_valid <= 1'b1;
    end else if (result_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit && !stall) begin
      out_data <= bright;
    end
  end

  assign result_ch.valid              = out_valid;
  assign result_ch.brightness_percent = out_data;

endmodule
`default_nettype wire

### rtl/core/alab_checker.sv
// Checker: port-level assertions on the auto-brightness block, with bind.
`timescale 1ns / 1ps
`default_nettype none
module alab_checker (
  input wire       clk,
  input wire       rst,
  input wire       in_valid,
  input wire       in_ready,
  input wire       out_valid,
  input wire       out_ready,
  input wire [6:0] brightness
);

  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (brightness >= 7'd1) && (brightness <= 7'd100))
    else $error("brightness out of range");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(brightness))
    else $error("stalled result changed");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second transfer taken while busy");

  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind ambient_light_auto_brightness alab_checker u_alab_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (sample_ch.valid),
  .in_ready   (sample_ch.ready),
  .out_valid  (result_ch.valid),
  .out_ready  (result_ch.ready),
  .brightness (result_ch.brightness_percent)
);
`default_nettype wire
